// ===== rtl/core/scrolling_arrow_pixel_generator_macros.svh =====
// Assertion helpers for the scrolling arrow pixel generator.
`ifndef SCROLLING_ARROW_PIXEL_GENERATOR_MACROS_SVH
`define SCROLLING_ARROW_PIXEL_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define SAPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAPG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SAPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/sapg_pkg.sv =====
package sapg_pkg;

    typedef enum logic [1:0] {
        FUNC_UP    = 2'd0,
        FUNC_LEFT  = 2'd1,
        FUNC_RIGHT = 2'd2,
        FUNC_BLANK = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_UP_RED     = 3'd0,
        CFG_UP_GREEN   = 3'd1,
        CFG_UP_BLUE    = 3'd2,
        CFG_TURN_RED   = 3'd3,
        CFG_TURN_GREEN = 3'd4,
        CFG_TURN_BLUE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam color_t UP_COLOR_RESET   = '{red: 8'd32, green: 8'd32, blue: 8'd32};
    localparam color_t TURN_COLOR_RESET = '{red: 8'd64, green: 8'd32, blue: 8'd0};

    localparam logic [7:0] TIP_LO    = 8'd7;
    localparam logic [7:0] TIP_HI    = 8'd8;
    localparam logic [7:0] MID_LO    = 8'd6;
    localparam logic [7:0] MID_HI    = 8'd9;
    localparam logic [7:0] WIDE_LO   = 8'd5;
    localparam logic [7:0] WIDE_HI   = 8'd10;
    localparam logic [7:0] SHAFT_END = 8'd11;

    // Distance d from the tip along the scroll axis, cross coordinate a.
    function automatic logic in_arrow(input logic [7:0] d, input logic [7:0] a);
        logic hit;
        if (d == 8'd0) begin
            hit = (a >= TIP_LO) && (a <= TIP_HI);
        end else if (d == 8'd1) begin
            hit = (a >= MID_LO) && (a <= MID_HI);
        end else if (d == 8'd2) begin
            hit = (a >= WIDE_LO) && (a <= WIDE_HI);
        end else if (d < SHAFT_END) begin
            hit = (a >= TIP_LO) && (a <= TIP_HI);
        end else begin
            hit = 1'b0;
        end
        return hit;
    endfunction

endpackage

// ===== rtl/core/sapg_locate.sv =====
module sapg_locate #(
    parameter int SIDE = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            in_func,
    input  logic [7:0]                            in_pos,
    input  logic [31:0]                           in_frame,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            out_func,
    output logic [$clog2(255 / SIDE + 1)-1:0]     out_y,
    output logic [$clog2(SIDE)-1:0]               out_x,
    output logic [$clog2(4 * 255 * (SIDE - 1) + 1)-1:0] out_sum,
    output logic [$clog2(4 * 255 * (SIDE - 1) + 1)-1:0] out_quot
);

    localparam int CW = $clog2(SIDE);
    localparam int YW = $clog2(255 / SIDE + 1);
    localparam int SW = $clog2(4 * 255 * (SIDE - 1) + 1);
    localparam int W1 = 256 % SIDE;
    localparam int W2 = 65536 % SIDE;
    localparam int W3 = 16777216 % SIDE;
    localparam int M1 = (65536 + SIDE - 1) / SIDE;
    localparam int M2 = (16777216 + SIDE - 1) / SIDE;

    logic          v1_reg;
    logic [1:0]    func1_reg;
    logic [7:0]    pos1_reg;
    logic [YW-1:0] y1_reg;
    logic [YW-1:0] y1_next;
    logic [SW-1:0] sum1_reg;
    logic [SW-1:0] sum1_next;
    logic [23:0]   prod1;
    logic          ready1;

    logic          v2_reg;
    logic [1:0]    func2_reg;
    logic [YW-1:0] y2_reg;
    logic [CW-1:0] x2_reg;
    logic [CW-1:0] x2_next;
    logic [SW-1:0] sum2_reg;
    logic [SW-1:0] quot2_reg;
    logic [SW-1:0] quot2_next;
    logic [7:0]    col2;
    logic [39:0]   prod2;
    logic          ready2;

    // Each byte of the frame count is weighted by 256^k mod SIDE.
    always_comb begin
        sum1_next = SW'(32'(in_frame[7:0])
                        + 32'(in_frame[15:8]) * 32'(W1)
                        + 32'(in_frame[23:16]) * 32'(W2)
                        + 32'(in_frame[31:24]) * 32'(W3));
        prod1     = 24'(in_pos) * 24'(M1);
        y1_next   = prod1[16 +: YW];
    end

    always_comb begin
        col2       = pos1_reg - 8'(32'(y1_reg) * SIDE);
        x2_next    = y1_reg[0] ? (CW'(SIDE - 1) - CW'(col2)) : CW'(col2);
        prod2      = 40'(sum1_reg) * 40'(M2);
        quot2_next = prod2[24 +: SW];
    end

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            func1_reg <= in_func;
            pos1_reg  <= in_pos;
            y1_reg    <= y1_next;
            sum1_reg  <= sum1_next;
        end
        if (ready2) begin
            func2_reg <= func1_reg;
            y2_reg    <= y1_reg;
            x2_reg    <= x2_next;
            sum2_reg  <= sum1_reg;
            quot2_reg <= quot2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_func  = func2_reg;
    assign out_y     = y2_reg;
    assign out_x     = x2_reg;
    assign out_sum   = sum2_reg;
    assign out_quot  = quot2_reg;

endmodule

// ===== rtl/core/sapg_wrap.sv =====
module sapg_wrap #(
    parameter int SIDE = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            in_func,
    input  logic [$clog2(255 / SIDE + 1)-1:0]     in_y,
    input  logic [$clog2(SIDE)-1:0]               in_x,
    input  logic [$clog2(4 * 255 * (SIDE - 1) + 1)-1:0] in_sum,
    input  logic [$clog2(4 * 255 * (SIDE - 1) + 1)-1:0] in_quot,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            out_func,
    output logic [$clog2(255 / SIDE + 1)-1:0]     out_y,
    output logic [$clog2(SIDE)-1:0]               out_x,
    output logic [$clog2(SIDE)-1:0]               out_f
);

    localparam int CW = $clog2(SIDE);
    localparam int YW = $clog2(255 / SIDE + 1);
    localparam int SW = $clog2(4 * 255 * (SIDE - 1) + 1);

    logic          v_reg;
    logic [1:0]    func_reg;
    logic [YW-1:0] y_reg;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] f_reg;
    logic [CW-1:0] f_next;
    logic [SW-1:0] rem;

    always_comb begin
        rem    = in_sum - SW'(32'(in_quot) * SIDE);
        f_next = CW'(rem);
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            func_reg <= in_func;
            y_reg    <= in_y;
            x_reg    <= in_x;
            f_reg    <= f_next;
        end
    end

    assign out_valid = v_reg;
    assign out_func  = func_reg;
    assign out_y     = y_reg;
    assign out_x     = x_reg;
    assign out_f     = f_reg;

endmodule

// ===== rtl/core/sapg_shade.sv =====
module sapg_shade #(
    parameter int SIDE = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_func,
    input  logic [$clog2(255 / SIDE + 1)-1:0] in_y,
    input  logic [$clog2(SIDE)-1:0]           in_x,
    input  logic [$clog2(SIDE)-1:0]           in_f,
    input  sapg_pkg::color_t                  up_color,
    input  sapg_pkg::color_t                  turn_color,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_red,
    output logic [7:0]                        out_green,
    output logic [7:0]                        out_blue,
    output logic                              out_lit
);

    localparam int CW = $clog2(SIDE);

    logic             v_reg;
    sapg_pkg::color_t color_reg;
    sapg_pkg::color_t color_next;
    logic             lit_reg;
    logic             lit_next;
    logic             in_grid;
    logic [CW-1:0]    y_c;
    logic [CW:0]      side_w;
    logic [CW:0]      sum_up;
    logic [CW:0]      sum_left;
    logic [CW:0]      d_up;
    logic [CW:0]      d_left;
    logic [CW:0]      d_right;
    sapg_pkg::color_t color_sel;

    always_comb begin
        in_grid  = 32'(in_y) < SIDE;
        y_c      = CW'(in_y);
        side_w   = (CW + 1)'(SIDE);
        sum_up   = (CW + 1)'(y_c) + (CW + 1)'(in_f);
        sum_left = (CW + 1)'(in_x) + (CW + 1)'(in_f);
        d_up     = (sum_up >= side_w) ? (sum_up - side_w) : sum_up;
        d_left   = (sum_left >= side_w) ? (sum_left - side_w) : sum_left;
        if (in_f >= in_x) begin
            d_right = (CW + 1)'(in_f) - (CW + 1)'(in_x);
        end else begin
            d_right = (CW + 1)'(in_f) + side_w - (CW + 1)'(in_x);
        end

        case (in_func)
            sapg_pkg::FUNC_UP: begin
                lit_next  = in_grid && sapg_pkg::in_arrow(8'(d_up), 8'(in_x));
                color_sel = up_color;
            end
            sapg_pkg::FUNC_LEFT: begin
                lit_next  = in_grid && sapg_pkg::in_arrow(8'(d_left), 8'(y_c));
                color_sel = turn_color;
            end
            sapg_pkg::FUNC_RIGHT: begin
                lit_next  = in_grid && sapg_pkg::in_arrow(8'(d_right), 8'(y_c));
                color_sel = turn_color;
            end
            default: begin
                lit_next  = 1'b0;
                color_sel = '0;
            end
        endcase

        color_next = lit_next ? color_sel : '0;
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            color_reg <= color_next;
            lit_reg   <= lit_next;
        end
    end

    assign out_valid = v_reg;
    assign out_red   = color_reg.red;
    assign out_green = color_reg.green;
    assign out_blue  = color_reg.blue;
    assign out_lit   = lit_reg;

endmodule

// ===== rtl/core/scrolling_arrow_pixel_generator.sv =====
// Scrolling arrow pixel generator: one LED color per item, for a SIDE x SIDE serpentine
// strip. The block takes one item every cycle while the output is not stalled, and
// passes it through four register stages: byte-weighted frame count folding with the
// row split, the reciprocal multiply that finds the frame quotient and the column, the
// remainder that yields the frame phase, and the arrow test with color select in the
// output register. A stalled output holds only the stages that are full; empty stages
// upstream keep taking items. Color registers are written through the cfg channel,
// which is always ready.
`include "scrolling_arrow_pixel_generator_macros.svh"

module scrolling_arrow_pixel_generator #(
    parameter int SIDE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_strip_position,
    input  logic [31:0] s_frame_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic        m_lit,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CW = $clog2(SIDE);
    localparam int YW = $clog2(255 / SIDE + 1);
    localparam int SW = $clog2(4 * 255 * (SIDE - 1) + 1);

    sapg_pkg::color_t up_color_reg;
    sapg_pkg::color_t up_color_next;
    sapg_pkg::color_t turn_color_reg;
    sapg_pkg::color_t turn_color_next;

    logic          loc_valid;
    logic          loc_ready;
    logic [1:0]    loc_func;
    logic [YW-1:0] loc_y;
    logic [CW-1:0] loc_x;
    logic [SW-1:0] loc_sum;
    logic [SW-1:0] loc_quot;

    logic          wrap_valid;
    logic          wrap_ready;
    logic [1:0]    wrap_func;
    logic [YW-1:0] wrap_y;
    logic [CW-1:0] wrap_x;
    logic [CW-1:0] wrap_f;

    assign cfg_ready = 1'b1;

    always_comb begin
        up_color_next   = up_color_reg;
        turn_color_next = turn_color_reg;
        if (cfg_valid) begin
            case (sapg_pkg::cfg_index_t'(cfg_index))
                sapg_pkg::CFG_UP_RED:     up_color_next.red     = cfg_data;
                sapg_pkg::CFG_UP_GREEN:   up_color_next.green   = cfg_data;
                sapg_pkg::CFG_UP_BLUE:    up_color_next.blue    = cfg_data;
                sapg_pkg::CFG_TURN_RED:   turn_color_next.red   = cfg_data;
                sapg_pkg::CFG_TURN_GREEN: turn_color_next.green = cfg_data;
                sapg_pkg::CFG_TURN_BLUE:  turn_color_next.blue  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_color_reg   <= sapg_pkg::UP_COLOR_RESET;
            turn_color_reg <= sapg_pkg::TURN_COLOR_RESET;
        end else begin
            up_color_reg   <= up_color_next;
            turn_color_reg <= turn_color_next;
        end
    end

    sapg_locate #(
        .SIDE(SIDE)
    ) u_locate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_pos    (s_strip_position),
        .in_frame  (s_frame_count),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .out_func  (loc_func),
        .out_y     (loc_y),
        .out_x     (loc_x),
        .out_sum   (loc_sum),
        .out_quot  (loc_quot)
    );

    sapg_wrap #(
        .SIDE(SIDE)
    ) u_wrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_func   (loc_func),
        .in_y      (loc_y),
        .in_x      (loc_x),
        .in_sum    (loc_sum),
        .in_quot   (loc_quot),
        .out_valid (wrap_valid),
        .out_ready (wrap_ready),
        .out_func  (wrap_func),
        .out_y     (wrap_y),
        .out_x     (wrap_x),
        .out_f     (wrap_f)
    );

    sapg_shade #(
        .SIDE(SIDE)
    ) u_shade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (wrap_valid),
        .in_ready   (wrap_ready),
        .in_func    (wrap_func),
        .in_y       (wrap_y),
        .in_x       (wrap_x),
        .in_f       (wrap_f),
        .up_color   (up_color_reg),
        .turn_color (turn_color_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_red    (m_red),
        .out_green  (m_green),
        .out_blue   (m_blue),
        .out_lit    (m_lit)
    );

    `SAPG_ASSERT_IMPL(a_unlit_black, aclk, aresetn, m_valid && !m_lit, m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0)
    `SAPG_ASSERT_IMPL(a_lit_color, aclk, aresetn, m_valid && m_lit, (m_red == up_color_reg.red && m_green == up_color_reg.green && m_blue == up_color_reg.blue) || (m_red == turn_color_reg.red && m_green == turn_color_reg.green && m_blue == turn_color_reg.blue))
    `SAPG_ASSERT_IMPL(a_drain_frees_input, aclk, aresetn, m_ready, s_ready)
    `SAPG_ASSERT_NEXT(a_cfg_up_red, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == sapg_pkg::CFG_UP_RED, up_color_reg.red == $past(cfg_data))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned GRID_SIDE   = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 90;
    // This index lies past the last color register, so a write to it must change nothing.
    localparam logic [2:0]  CFG_SPARE_INDEX = 3'd6;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
    } pixel_t;

    typedef struct {
        sapg_pkg::func_t fn;
        logic [7:0]      pos;
        logic [31:0]     frame;
        bit              typed;
        pixel_t          want;
    } pixel_vector_t;

    localparam pixel_t DARK     = '0;
    localparam pixel_t UP_LIT   = '{8'd32, 8'd32, 8'd32, 1'b1};
    localparam pixel_t TURN_LIT = '{8'd64, 8'd32, 8'd0, 1'b1};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [7:0]  s_strip_position;
    logic [31:0] s_frame_count;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_lit;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    sapg_pkg::color_t up_color;
    sapg_pkg::color_t turn_color;
    pixel_t           expected_pixels[$];
    pixel_t           head_pixel;
    int               mismatch_count = 0;
    int unsigned      cycle_count = 0;
    bit               send_idle;
    bit               recv_idle;

    pixel_vector_t directed_vectors [23] = '{
        '{sapg_pkg::FUNC_UP,    8'd7,   32'd0,          1'b1, UP_LIT},
        '{sapg_pkg::FUNC_UP,    8'd0,   32'd0,          1'b1, DARK},
        '{sapg_pkg::FUNC_UP,    8'd8,   32'd0,          1'b1, UP_LIT},
        '{sapg_pkg::FUNC_UP,    8'd6,   32'd0,          1'b1, DARK},
        '{sapg_pkg::FUNC_BLANK, 8'd7,   32'd0,          1'b1, DARK},
        '{sapg_pkg::FUNC_BLANK, 8'd255, 32'hFFFF_FFFF,  1'b1, DARK},
        '{sapg_pkg::FUNC_LEFT,  8'd127, 32'd0,          1'b1, TURN_LIT},
        '{sapg_pkg::FUNC_RIGHT, 8'd128, 32'd0,          1'b1, TURN_LIT},
        '{sapg_pkg::FUNC_UP,    8'd255, 32'hFFFF_FFFF,  1'b1, DARK},
        '{sapg_pkg::FUNC_UP,    8'd0,   32'hFFFF_FFFF,  1'b1, DARK},
        '{sapg_pkg::FUNC_UP,    8'd24,  32'd0,          1'b0, DARK},
        '{sapg_pkg::FUNC_UP,    8'd37,  32'd0,          1'b0, DARK},
        '{sapg_pkg::FUNC_UP,    8'd42,  32'd0,          1'b0, DARK},
        '{sapg_pkg::FUNC_UP,    8'd168, 32'd0,          1'b0, DARK},
        '{sapg_pkg::FUNC_UP,    8'd183, 32'd0,          1'b0, DARK},
        '{sapg_pkg::FUNC_UP,    8'd7,   32'h8000_0005,  1'b0, DARK},
        '{sapg_pkg::FUNC_LEFT,  8'h55,  32'h5555_5555,  1'b0, DARK},
        '{sapg_pkg::FUNC_LEFT,  8'hAA,  32'hAAAA_AAAA,  1'b0, DARK},
        '{sapg_pkg::FUNC_RIGHT, 8'd255, 32'hFFFF_FFFF,  1'b0, DARK},
        '{sapg_pkg::FUNC_RIGHT, 8'd0,   32'h7FFF_FFFF,  1'b0, DARK},
        '{sapg_pkg::FUNC_LEFT,  8'd112, 32'd1,          1'b0, DARK},
        '{sapg_pkg::FUNC_RIGHT, 8'd143, 32'd15,         1'b0, DARK},
        '{sapg_pkg::FUNC_BLANK, 8'd0,   32'h1234_5678,  1'b0, DARK}
    };

    scrolling_arrow_pixel_generator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_strip_position (s_strip_position),
        .s_frame_count    (s_frame_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_lit            (m_lit),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic bit on_arrow_shape(int unsigned along, int unsigned lateral);
        bit hit;
        if (along == 0) begin
            hit = (lateral >= 7) && (lateral <= 8);
        end else if (along == 1) begin
            hit = (lateral >= 6) && (lateral <= 9);
        end else if (along == 2) begin
            hit = (lateral >= 5) && (lateral <= 10);
        end else if (along <= 10) begin
            hit = (lateral >= 7) && (lateral <= 8);
        end else begin
            hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic pixel_t predict_pixel(sapg_pkg::func_t fn, logic [7:0] pos,
                                             logic [31:0] frame);
        int unsigned      phase;
        int unsigned      row;
        int unsigned      col;
        int unsigned      x;
        int unsigned      along;
        int unsigned      lateral;
        sapg_pkg::color_t hue;
        bit               lit;
        pixel_t           px;
        phase = frame % GRID_SIDE;
        row = pos / GRID_SIDE;
        col = pos % GRID_SIDE;
        lit = 1'b0;
        hue = '0;
        if (row < GRID_SIDE) begin
            x = (row % 2 == 1) ? GRID_SIDE - 1 - col : col;
            case (fn)
                sapg_pkg::FUNC_UP: begin
                    along = (row + phase) % GRID_SIDE;
                    lateral = x;
                    hue = up_color;
                    lit = on_arrow_shape(along, lateral);
                end
                sapg_pkg::FUNC_LEFT: begin
                    along = (x + phase) % GRID_SIDE;
                    lateral = row;
                    hue = turn_color;
                    lit = on_arrow_shape(along, lateral);
                end
                sapg_pkg::FUNC_RIGHT: begin
                    along = (phase + GRID_SIDE - x) % GRID_SIDE;
                    lateral = row;
                    hue = turn_color;
                    lit = on_arrow_shape(along, lateral);
                end
                default: begin
                    lit = 1'b0;
                end
            endcase
        end
        px = DARK;
        if (lit) begin
            px = '{hue.red, hue.green, hue.blue, 1'b1};
        end
        return px;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic write_color_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sapg_pkg::CFG_UP_RED:     up_color.red = val;
            sapg_pkg::CFG_UP_GREEN:   up_color.green = val;
            sapg_pkg::CFG_UP_BLUE:    up_color.blue = val;
            sapg_pkg::CFG_TURN_RED:   turn_color.red = val;
            sapg_pkg::CFG_TURN_GREEN: turn_color.green = val;
            sapg_pkg::CFG_TURN_BLUE:  turn_color.blue = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_colors(sapg_pkg::color_t up_set, sapg_pkg::color_t turn_set);
        write_color_reg(sapg_pkg::CFG_UP_RED, up_set.red);
        write_color_reg(sapg_pkg::CFG_UP_GREEN, up_set.green);
        write_color_reg(sapg_pkg::CFG_UP_BLUE, up_set.blue);
        write_color_reg(sapg_pkg::CFG_TURN_RED, turn_set.red);
        write_color_reg(sapg_pkg::CFG_TURN_GREEN, turn_set.green);
        write_color_reg(sapg_pkg::CFG_TURN_BLUE, turn_set.blue);
    endtask

    task automatic send_pixel_request(sapg_pkg::func_t fn, logic [7:0] pos, logic [31:0] frame,
                                      bit typed, pixel_t typed_px);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func <= fn;
        s_strip_position <= pos;
        s_frame_count <= frame;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(typed ? typed_px : predict_pixel(fn, pos, frame));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result with no item pending: %0d %0d %0d lit %0d",
                                          m_red, m_green, m_blue, m_lit));
            end else begin
                head_pixel = expected_pixels.pop_front();
                if (m_red !== head_pixel.red)
                    report_mismatch($sformatf("red got %0d expected %0d",
                                              m_red, head_pixel.red));
                if (m_green !== head_pixel.green)
                    report_mismatch($sformatf("green got %0d expected %0d",
                                              m_green, head_pixel.green));
                if (m_blue !== head_pixel.blue)
                    report_mismatch($sformatf("blue got %0d expected %0d",
                                              m_blue, head_pixel.blue));
                if (m_lit !== head_pixel.lit)
                    report_mismatch($sformatf("lit got %0d expected %0d",
                                              m_lit, head_pixel.lit));
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = recv_idle ? $urandom_range(0, 17) : 0;
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
        end
    end

    initial begin : stimulus
        int               i;
        int               phase;
        sapg_pkg::color_t up_set;
        sapg_pkg::color_t turn_set;
        logic [31:0]      frame;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = sapg_pkg::FUNC_UP;
        s_strip_position = '0;
        s_frame_count = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sapg_pkg::CFG_UP_RED;
        cfg_data = '0;
        up_color = sapg_pkg::UP_COLOR_RESET;
        turn_color = sapg_pkg::TURN_COLOR_RESET;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_vectors[k]) begin
            send_pixel_request(directed_vectors[k].fn, directed_vectors[k].pos,
                               directed_vectors[k].frame, directed_vectors[k].typed,
                               directed_vectors[k].want);
        end
        drain_results();

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    up_set = '0;
                    turn_set = '0;
                end
                1: begin
                    up_set = '1;
                    turn_set = '1;
                end
                3: begin
                    up_set = '{8'h55, 8'hAA, 8'h55};
                    turn_set = '{8'hAA, 8'h55, 8'hAA};
                end
                default: begin
                    up_set = sapg_pkg::color_t'($urandom);
                    turn_set = sapg_pkg::color_t'($urandom);
                end
            endcase
            program_colors(up_set, turn_set);
            if (phase == 4) begin
                write_color_reg(CFG_SPARE_INDEX, 8'($urandom_range(0, 255)));
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 30 == 0) begin
                    send_idle = $urandom_range(0, 3) != 0;
                    recv_idle = $urandom_range(0, 3) != 0;
                end
                case ($urandom_range(0, 3))
                    0: frame = $urandom_range(0, 15);
                    1: frame = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                    default: frame = $urandom;
                endcase
                send_pixel_request(sapg_pkg::func_t'($urandom_range(0, 3)),
                                   8'($urandom_range(0, 255)), frame, 1'b0, DARK);
            end
            drain_results();
        end

        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
